// ===== src/uvs_pkg.sv =====
`timescale 1ns / 1ps
// uvs_pkg: shared widths, constants and types of the uv sphere vertex generator
// used by every module of the block, depends on nothing
package uvs_pkg;

  localparam int CW       = 9;   // count and grid index width
  localparam int IDXW     = 17;  // vertex index width
  localparam int RADW     = 24;  // radius width, unsigned Q8.16
  localparam int POSW     = 25;  // position width, signed Q8.16
  localparam int NRMW     = 16;  // normal width, signed Q1.14
  localparam int ANGW     = 32;  // binary angle width
  localparam int QW       = ANGW + 1;  // quotient width of the angle divider
  localparam int CRDW     = 34;  // cordic datapath width
  localparam int TRGW     = 32;  // width of a clamped Q30 sine or cosine
  localparam int MULW     = 2 * TRGW;
  localparam int PPW      = RADW + 1 + TRGW;
  localparam int CFGW     = 2;   // register index width

  localparam int MAX_SECTORS_DEF  = 256;
  localparam int MAX_STACKS_DEF   = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_TAB_LEN   = 24;

  localparam logic [RADW-1:0] RADIUS_RST  = 24'd65536;
  localparam logic [CW-1:0]   SECTORS_RST = 9'd36;
  localparam logic [CW-1:0]   STACKS_RST  = 9'd18;
  localparam logic [CW-1:0]   MIN_SECTORS = 9'd3;
  localparam logic [CW-1:0]   MIN_STACKS  = 9'd2;

  localparam logic signed [CRDW-1:0] GAIN_Q30    = 34'sd652032875;
  localparam logic signed [CRDW-1:0] QUARTER_TRN = 34'sd1073741824;
  localparam logic signed [CRDW-1:0] HALF_TRN    = 34'sd2147483648;
  localparam logic [ANGW-1:0]        RING_OFS    = 32'h4000_0000;
  localparam logic signed [NRMW-1:0] NORM_LIM    = 16'sd16384;

  localparam logic [ANGW-1:0] ATAN_TAB [CORDIC_TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [CFGW-1:0] {
    REG_RADIUS  = 2'd0,
    REG_SECTORS = 2'd1,
    REG_STACKS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [IDXW-1:0] top;
    logic [IDXW-1:0] bottom;
    logic            upper;
    logic            lower;
    logic            oor;
  } uvs_side_t;

endpackage

// ===== src/uvs_div_pipe.sv =====
`timescale 1ns / 1ps
// uvs_div_pipe: pipelined long division floor(a * 2^32 / d) for a below 2 * d, one quotient bit per stage
// depends on uvs_pkg
module uvs_div_pipe
  import uvs_pkg::*;
(
  input  logic          clk_i,
  input  logic [CW-1:0] a_i,
  input  logic [CW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  localparam int NB = ANGW;

  logic [CW-1:0] r_q [NB+1];
  logic [QW-1:0] q_q [NB+1];
  logic          ge0;

  assign ge0 = (a_i >= d_i);

  // integer part first, then one fraction bit per stage
  always_ff @(posedge clk_i) begin
    r_q[0] <= ge0 ? (a_i - d_i) : a_i;
    q_q[0] <= {{(QW-1){1'b0}}, ge0};
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    logic [CW:0] r2;
    logic        ge;
    assign r2 = {r_q[k], 1'b0};
    assign ge = (r2 >= {1'b0, d_i});
    always_ff @(posedge clk_i) begin
      r_q[k+1] <= ge ? CW'(r2 - {1'b0, d_i}) : r2[CW-1:0];
      q_q[k+1] <= {q_q[k][QW-2:0], ge};
    end
  end

  assign q_o = q_q[NB];

endmodule

// ===== src/uvs_cordic.sv =====
`timescale 1ns / 1ps
// uvs_cordic: pipelined cordic rotator, binary angle in, clamped Q30 cosine and sine out
// depends on uvs_pkg
module uvs_cordic
  import uvs_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic [ANGW-1:0]        ang_i,
  output logic signed [TRGW-1:0] cos_o,
  output logic signed [TRGW-1:0] sin_o
);

  logic signed [CRDW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CRDW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CRDW-1:0] z_q [CORDIC_STEPS+1];
  logic                   neg_q [CORDIC_STEPS+1];
  logic signed [CRDW-1:0] z_raw, z_fold;
  logic                   neg_fold;
  logic signed [CRDW-1:0] xf, yf;

  // half-turn fold into the right half plane
  always_comb begin
    z_raw    = {{(CRDW-ANGW){ang_i[ANGW-1]}}, ang_i};
    z_fold   = z_raw;
    neg_fold = 1'b0;
    if (z_raw > QUARTER_TRN) begin
      z_fold   = z_raw - HALF_TRN;
      neg_fold = 1'b1;
    end else if (z_raw < -QUARTER_TRN) begin
      z_fold   = z_raw + HALF_TRN;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= GAIN_Q30;
    y_q[0]   <= '0;
    z_q[0]   <= z_fold;
    neg_q[0] <= neg_fold;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CRDW-1:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({{(CRDW-ANGW){1'b0}}, ATAN_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + at;
      end
      neg_q[i+1] <= neg_q[i];
    end
  end

  assign xf = neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
  assign yf = neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (xf > QUARTER_TRN)       cos_o <= TRGW'(QUARTER_TRN);
    else if (xf < -QUARTER_TRN) cos_o <= TRGW'(-QUARTER_TRN);
    else                        cos_o <= TRGW'(xf);
    if (yf > QUARTER_TRN)       sin_o <= TRGW'(QUARTER_TRN);
    else if (yf < -QUARTER_TRN) sin_o <= TRGW'(-QUARTER_TRN);
    else                        sin_o <= TRGW'(yf);
  end

endmodule

// ===== src/uvs_norm_pos.sv =====
`timescale 1ns / 1ps
// uvs_norm_pos: three-stage multiply pipeline from ring and slice sine/cosine
// to the Q30 normal and the radius-scaled products; depends on uvs_pkg
module uvs_norm_pos
  import uvs_pkg::*;
(
  input  logic                   clk_i,
  input  logic signed [TRGW-1:0] cr_i,
  input  logic signed [TRGW-1:0] sr_i,
  input  logic signed [TRGW-1:0] cs_i,
  input  logic signed [TRGW-1:0] ss_i,
  input  logic [RADW-1:0]        radius_i,
  output logic signed [TRGW-1:0] n_o  [3],
  output logic signed [PPW-1:0]  pp_o [3]
);

  localparam logic signed [MULW-1:0] RND30 = MULW'(64'sd536870912);

  logic signed [MULW-1:0] m0_q, m1_q;
  logic signed [TRGW-1:0] sr1_q;
  logic signed [TRGW-1:0] n_q [3];
  logic signed [MULW-1:0] r0, r1;

  always_ff @(posedge clk_i) begin
    m0_q  <= MULW'(cr_i * cs_i);
    m1_q  <= MULW'(cr_i * ss_i);
    sr1_q <= sr_i;
  end

  assign r0 = (m0_q + RND30) >>> 30;
  assign r1 = (m1_q + RND30) >>> 30;

  always_ff @(posedge clk_i) begin
    n_q[0] <= TRGW'(r0);
    n_q[1] <= TRGW'(r1);
    n_q[2] <= sr1_q;
  end

  for (genvar k = 0; k < 3; k++) begin : g_pos
    always_ff @(posedge clk_i) begin
      pp_o[k] <= PPW'($signed({1'b0, radius_i}) * n_q[k]);
      n_o[k]  <= n_q[k];
    end
  end

endmodule

// ===== src/uv_sphere_vertex_generator_core.sv =====
`timescale 1ns / 1ps
// uv_sphere_vertex_generator_core: top level, configuration registers, index logic,
// sideband delay line and output rounding; depends on uvs_pkg and all uvs_ modules
//
// Takes one grid point per clock cycle with no gaps; busy_o is never raised. Each item
// gives exactly one result, strobed by done_o for one cycle; its path runs through the
// 33-stage angle divider, the cordic pipeline (CORDIC_STEPS + 2 stages) and four
// multiply and rounding stages. Results cannot be held off, so the receiver must take
// every strobe. Configuration writes are taken at once and must only be made while no
// item is in flight.
module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
#(
  parameter int MAX_SECTORS  = MAX_SECTORS_DEF,
  parameter int MAX_STACKS   = MAX_STACKS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFGW-1:0]        cfg_idx_i,
  input  logic [RADW-1:0]        cfg_wdata_i,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [CW-1:0]          ring_index_i,
  input  logic [CW-1:0]          slice_index_i,
  output logic                   done_o,
  output logic signed [POSW-1:0] pos_x_o,
  output logic signed [POSW-1:0] pos_y_o,
  output logic signed [POSW-1:0] pos_z_o,
  output logic signed [NRMW-1:0] norm_x_o,
  output logic signed [NRMW-1:0] norm_y_o,
  output logic signed [NRMW-1:0] norm_z_o,
  output logic [IDXW-1:0]        top_index_o,
  output logic [IDXW-1:0]        bottom_index_o,
  output logic                   upper_tri_valid_o,
  output logic                   lower_tri_valid_o,
  output logic                   out_of_range_o
);

  localparam int SIDE_LEN = CORDIC_STEPS + 38;
  localparam int LAT      = SIDE_LEN + 1;
  localparam logic signed [PPW-1:0]  RND30 = PPW'(64'sd536870912);
  localparam logic signed [TRGW-1:0] RND16 = TRGW'(32'sd32768);

  logic [RADW-1:0] radius_q;
  logic [CW-1:0]   sectors_q, stacks_q;
  logic [CW-1:0]   sec_eff, stk_eff;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      sectors_q <= SECTORS_RST;
      stacks_q  <= STACKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RADIUS:  radius_q  <= cfg_wdata_i;
        REG_SECTORS: sectors_q <= cfg_wdata_i[CW-1:0];
        REG_STACKS:  stacks_q  <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the supported range
  always_comb begin
    sec_eff = sectors_q;
    if (sectors_q < MIN_SECTORS) sec_eff = MIN_SECTORS;
    else if (32'(sectors_q) > MAX_SECTORS) sec_eff = CW'(MAX_SECTORS);
    stk_eff = stacks_q;
    if (stacks_q < MIN_STACKS) stk_eff = MIN_STACKS;
    else if (32'(stacks_q) > MAX_STACKS) stk_eff = CW'(MAX_STACKS);
  end

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // quad indices and triangle flags
  uvs_side_t side_in;
  logic [2*CW:0] top_full;

  always_comb begin
    top_full       = ring_index_i * ({1'b0, sec_eff} + 1'b1) + (2*CW+1)'(slice_index_i);
    side_in.top    = top_full[IDXW-1:0];
    side_in.bottom = top_full[IDXW-1:0] + IDXW'(sec_eff) + 1'b1;
    side_in.upper  = (ring_index_i != '0) && (ring_index_i < stk_eff)
                     && (slice_index_i < sec_eff);
    side_in.lower  = ({1'b0, ring_index_i} + 1'b1 < {1'b0, stk_eff})
                     && (slice_index_i < sec_eff);
    side_in.oor    = (ring_index_i > stk_eff) || (slice_index_i > sec_eff);
  end

  uvs_side_t side_q [SIDE_LEN];
  logic      vld_q  [SIDE_LEN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SIDE_LEN; j++) vld_q[j] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int j = 1; j < SIDE_LEN; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int j = 1; j < SIDE_LEN; j++) side_q[j] <= side_q[j-1];
  end

  // angles
  logic [QW-1:0]   q_ring, q_slice;
  logic [ANGW-1:0] ring_ang, slice_ang;

  uvs_div_pipe u_div_ring (
    .clk_i (clk_i),
    .a_i   (ring_index_i),
    .d_i   (stk_eff),
    .q_o   (q_ring)
  );

  uvs_div_pipe u_div_slice (
    .clk_i (clk_i),
    .a_i   (slice_index_i),
    .d_i   (sec_eff),
    .q_o   (q_slice)
  );

  assign ring_ang  = RING_OFS - q_ring[QW-1:1];
  assign slice_ang = q_slice[ANGW-1:0];

  logic signed [TRGW-1:0] cr, sr, cs, ss;

  uvs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_ring (
    .clk_i (clk_i),
    .ang_i (ring_ang),
    .cos_o (cr),
    .sin_o (sr)
  );

  uvs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_slice (
    .clk_i (clk_i),
    .ang_i (slice_ang),
    .cos_o (cs),
    .sin_o (ss)
  );

  logic signed [TRGW-1:0] n  [3];
  logic signed [PPW-1:0]  pp [3];

  uvs_norm_pos u_norm_pos (
    .clk_i    (clk_i),
    .cr_i     (cr),
    .sr_i     (sr),
    .cs_i     (cs),
    .ss_i     (ss),
    .radius_i (radius_q),
    .n_o      (n),
    .pp_o     (pp)
  );

  // output rounding and clamping
  logic signed [POSW-1:0] pos_d  [3];
  logic signed [NRMW-1:0] norm_d [3];
  uvs_side_t              side_last;

  assign side_last = side_q[SIDE_LEN-1];

  for (genvar k = 0; k < 3; k++) begin : g_out
    logic signed [PPW-1:0]  pr;
    logic signed [TRGW-1:0] nr;
    assign pr = (pp[k] + RND30) >>> 30;
    assign nr = (n[k] + RND16) >>> 16;
    always_comb begin
      pos_d[k] = POSW'(pr);
      if (nr > TRGW'(NORM_LIM))       norm_d[k] = NORM_LIM;
      else if (nr < -TRGW'(NORM_LIM)) norm_d[k] = -NORM_LIM;
      else                            norm_d[k] = NRMW'(nr);
      if (side_last.oor) begin
        pos_d[k]  = '0;
        norm_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vld_q[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_o           <= pos_d[0];
    pos_y_o           <= pos_d[1];
    pos_z_o           <= pos_d[2];
    norm_x_o          <= norm_d[0];
    norm_y_o          <= norm_d[1];
    norm_z_o          <= norm_d[2];
    top_index_o       <= side_last.oor ? '0 : side_last.top;
    bottom_index_o    <= side_last.oor ? '0 : side_last.bottom;
    upper_tri_valid_o <= side_last.upper && !side_last.oor;
    lower_tri_valid_o <= side_last.lower && !side_last.oor;
    out_of_range_o    <= side_last.oor;
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after pipeline latency");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> pos_x_o == '0 && norm_z_o == '0 && top_index_o == '0
      && !upper_tri_valid_o && !lower_tri_valid_o)
    else $error("out of range item with nonzero fields");

  a_norm_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> norm_x_o <= NORM_LIM && norm_x_o >= -NORM_LIM
      && norm_z_o <= NORM_LIM && norm_z_o >= -NORM_LIM)
    else $error("normal component beyond unit range");

  a_no_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[SIDE_LEN-1] |=> !done_o)
    else $error("result strobe without an item in flight");

endmodule
